// ===== rtl/dns_name_label_codec_core_defines.svh =====
// ----------------------------------------------------------------------------
// dns_name_label_codec_core_defines.svh
// Assertion macros used by the DNS name label codec top-level core.
// ----------------------------------------------------------------------------
`ifndef DNS_NAME_LABEL_CODEC_CORE_DEFINES_SVH
`define DNS_NAME_LABEL_CODEC_CORE_DEFINES_SVH

// Same-cycle implication, checked on i_clk, off during reset.
`define DNLC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dnlc assertion failed");

// Next-cycle implication, checked on i_clk, off during reset.
`define DNLC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dnlc assertion failed");

`endif

// ===== rtl/dnlc_pkg.sv =====
// ----------------------------------------------------------------------------
// dnlc_pkg
// Types and constants of the DNS name label codec.
// ----------------------------------------------------------------------------
`default_nettype none

package dnlc_pkg;

    localparam int         FILL_W   = 6;
    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic [7:0] PTR_MASK = 8'hC0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_CHR,
        S_DOT,
        S_END
    } t_state;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_IN,
        OUT_LEN,
        OUT_CHR,
        OUT_DOT,
        OUT_TERM
    } t_out_sel;

    typedef struct packed {
        t_out_sel out_sel;
        logic     out_last;
        logic     store_wr;
        logic     fill_clr;
        logic     left_load;
        logic     left_dec;
        logic     err_set;
        logic     end_clr;
        logic     k_clr;
        logic     k_inc;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic is_zero;
        logic is_dot;
        logic bad_len;
        logic fill_zero;
        logic fill_full;
        logic left_zero;
        logic left_one;
        logic k_last;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/dnlc_ram.sv =====
// ----------------------------------------------------------------------------
// dnlc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dnlc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 62,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/dnlc_datapath.sv =====
// ----------------------------------------------------------------------------
// dnlc_datapath
// Label store, fill/length counters, sticky error and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dnlc_datapath #(
    parameter int LABEL_MAX = 62
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [7:0]       i_in_byte,
    input  wire logic             i_out_ready,
    input  wire dnlc_pkg::t_cmd   i_cmd,
    output dnlc_pkg::t_status     o_status,
    output logic                  o_out_valid,
    output logic      [7:0]       o_out_byte,
    output logic                  o_out_last,
    output logic                  o_out_done,
    output logic                  o_out_err
);

    import dnlc_pkg::*;

    localparam int ADDR_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

    logic [FILL_W-1:0] r_fill, n_fill;
    logic [FILL_W-1:0] r_left, n_left;
    logic              r_err, n_err;
    logic [ADDR_W-1:0] r_k, n_k;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_out_done;
    logic              r_out_err;
    logic [7:0]        w_rdata;
    logic [7:0]        w_byte;
    logic              w_done;
    logic              w_err;

    dnlc_ram #(
        .WIDTH (8),
        .DEPTH (LABEL_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store_wr),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (i_in_byte),
        .i_raddr (n_k),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_fill = r_fill;
        n_left = r_left;
        n_err  = r_err;
        n_k    = r_k;
        if (i_cmd.store_wr) begin
            n_fill = r_fill + FILL_W'(1);
        end
        if (i_cmd.fill_clr) begin
            n_fill = '0;
        end
        if (i_cmd.left_load) begin
            n_left = i_in_byte[FILL_W-1:0];
        end else if (i_cmd.left_dec) begin
            n_left = r_left - FILL_W'(1);
        end
        if (i_cmd.err_set) begin
            n_err = 1'b1;
        end
        if (i_cmd.end_clr) begin
            n_fill = '0;
            n_left = '0;
            n_err  = 1'b0;
        end
        if (i_cmd.k_clr) begin
            n_k = '0;
        end else if (i_cmd.k_inc) begin
            n_k = r_k + ADDR_W'(1);
        end
    end

    always_comb begin
        w_byte = 8'h00;
        w_done = 1'b0;
        w_err  = 1'b0;
        unique case (i_cmd.out_sel)
            OUT_IN:   w_byte = i_in_byte;
            OUT_LEN:  w_byte = 8'(r_fill);
            OUT_CHR:  w_byte = w_rdata;
            OUT_DOT:  w_byte = DOT_CHAR;
            OUT_TERM: begin
                w_done = 1'b1;
                w_err  = r_err | i_cmd.err_set;
            end
            default:  w_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_left      <= '0;
            r_err       <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_left <= n_left;
            r_err  <= n_err;
            r_k    <= n_k;
            if (i_cmd.out_sel != OUT_NONE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_sel != OUT_NONE) begin
            r_out_byte <= w_byte;
            r_out_last <= i_cmd.out_last;
            r_out_done <= w_done;
            r_out_err  <= w_err;
        end
    end

    always_comb begin
        o_status.out_free  = !r_out_valid || i_out_ready;
        o_status.is_zero   = (i_in_byte == 8'h00);
        o_status.is_dot    = (i_in_byte == DOT_CHAR);
        o_status.bad_len   = ((i_in_byte & PTR_MASK) == PTR_MASK)
                             || (i_in_byte > 8'(LABEL_MAX));
        o_status.fill_zero = (r_fill == '0);
        o_status.fill_full = (r_fill == FILL_W'(LABEL_MAX));
        o_status.left_zero = (r_left == '0);
        o_status.left_one  = (r_left == FILL_W'(1));
        o_status.k_last    = (FILL_W'(r_k) == r_fill - FILL_W'(1));
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_out_done  = r_out_done;
    assign o_out_err   = r_out_err;

endmodule

`default_nettype wire

// ===== rtl/dnlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dnlc_ctrl
// Controller: direction register, byte decisions and label drain sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module dnlc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_wr_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire dnlc_pkg::t_status i_status,
    output dnlc_pkg::t_cmd         o_cmd
);

    import dnlc_pkg::*;

    t_state r_state, n_state;
    logic   r_dir;
    logic   r_end_pend, n_end_pend;
    logic   w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_dir      <= 1'b0;
            r_end_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_end_pend <= n_end_pend;
            if (i_cfg_wr_en) begin
                r_dir <= i_cfg_wr_data;
            end
        end
    end

    assign w_take = i_in_valid && i_status.out_free;

    always_comb begin
        n_state    = r_state;
        n_end_pend = r_end_pend;
        o_in_ready = 1'b0;
        o_cmd      = '{out_sel: OUT_NONE, default: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_status.out_free;
                if (w_take) begin
                    if (!r_dir) begin
                        if (i_status.is_zero) begin
                            if (i_status.fill_zero) begin
                                o_cmd.out_sel  = OUT_TERM;
                                o_cmd.out_last = 1'b1;
                                o_cmd.end_clr  = 1'b1;
                            end else begin
                                n_end_pend = 1'b1;
                                n_state    = S_LEN;
                            end
                        end else if (i_status.is_dot) begin
                            if (!i_status.fill_zero) begin
                                n_end_pend = 1'b0;
                                n_state    = S_LEN;
                            end
                        end else if (!i_status.fill_full) begin
                            o_cmd.store_wr = 1'b1;
                        end else begin
                            o_cmd.err_set = 1'b1;
                        end
                    end else if (i_status.left_zero) begin
                        if (i_status.is_zero) begin
                            o_cmd.out_sel  = OUT_TERM;
                            o_cmd.out_last = 1'b1;
                            o_cmd.end_clr  = 1'b1;
                        end else if (i_status.bad_len) begin
                            o_cmd.err_set = 1'b1;
                        end else begin
                            o_cmd.left_load = 1'b1;
                        end
                    end else if (i_status.is_zero) begin
                        o_cmd.err_set  = 1'b1;
                        o_cmd.out_sel  = OUT_TERM;
                        o_cmd.out_last = 1'b1;
                        o_cmd.end_clr  = 1'b1;
                    end else begin
                        o_cmd.out_sel  = OUT_IN;
                        o_cmd.left_dec = 1'b1;
                        o_cmd.out_last = !i_status.left_one;
                        if (i_status.left_one) begin
                            n_state = S_DOT;
                        end
                    end
                end
            end
            S_LEN: begin
                if (i_status.out_free) begin
                    o_cmd.out_sel = OUT_LEN;
                    n_state       = S_CHR;
                end
            end
            S_CHR: begin
                if (i_status.out_free) begin
                    o_cmd.out_sel  = OUT_CHR;
                    o_cmd.out_last = i_status.k_last && !r_end_pend;
                    o_cmd.k_inc    = 1'b1;
                    if (i_status.k_last) begin
                        o_cmd.k_clr    = 1'b1;
                        o_cmd.fill_clr = 1'b1;
                        n_state        = r_end_pend ? S_END : S_IDLE;
                    end
                end
            end
            S_DOT: begin
                if (i_status.out_free) begin
                    o_cmd.out_sel  = OUT_DOT;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_END: begin
                if (i_status.out_free) begin
                    o_cmd.out_sel  = OUT_TERM;
                    o_cmd.out_last = 1'b1;
                    o_cmd.end_clr  = 1'b1;
                    n_end_pend     = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/dns_name_label_codec_core.sv =====
// ----------------------------------------------------------------------------
// dns_name_label_codec_core
// Converts dotted domain names to DNS wire labels and back, one byte a
// transfer in, zero or more bytes out.
// ----------------------------------------------------------------------------
//  Channel | Dir | Ports              | Content
//  --------+-----+--------------------+---------------------------------------
//  s_axis  | in  | i_s_axis_*         | tdata: in_byte
//  m_axis  | out | o_m_axis_*         | tdata: out_byte, tlast: run_last,
//          |     |                    | tuser: name_done, name_error
//  cfg     | in  | i_cfg_wr_*         | direction (0 encode, 1 decode)
//
//  Input is taken only when idle with the output register free; decode
//  label bytes therefore stream at one byte per cycle, and each label's dot
//  is sent from its own state. An encode flush sends the length byte, the
//  characters and, at end of name, the terminator, paced by the single
//  output register and one registered store read port; input is held off.
//  Synchronous active-low reset; the label store is not cleared.
//  A stalled output holds its transfer and blocks new input.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dns_name_label_codec_core_defines.svh"

module dns_name_label_codec_core #(
    parameter int LABEL_MAX = 62
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_wr_data,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic      [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic            o_m_axis_tlast,
    output logic      [1:0] o_m_axis_tuser    // [0] name_done, [1] name_error
);

    import dnlc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    dnlc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_s_axis_tvalid),
        .o_in_ready    (o_s_axis_tready),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    dnlc_datapath #(
        .LABEL_MAX (LABEL_MAX)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_byte   (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_byte  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast),
        .o_out_done  (o_m_axis_tuser[0]),
        .o_out_err   (o_m_axis_tuser[1])
    );

    `DNLC_ASSERT_IMPL(a_done_is_last, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tlast)
    `DNLC_ASSERT_IMPL(a_err_needs_done, o_m_axis_tvalid && o_m_axis_tuser[1], o_m_axis_tuser[0])
    `DNLC_ASSERT_IMPL(a_done_is_zero, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata == 8'h00)
    `DNLC_ASSERT_IMPL(a_no_take_on_stall, o_s_axis_tready, !o_m_axis_tvalid || i_m_axis_tready)

endmodule

`default_nettype wire
